>>> hdl/b2da_pkg.sv
// ---------------------------------------------------------------------------
// b2da_pkg
// Shared widths, constants, reciprocal table and control structs for the
// binary to decimal ASCII converter.
// ---------------------------------------------------------------------------
package b2da_pkg;

	localparam int VALUE_W = 16;
	localparam int DIGIT_W = 4;
	localparam int CHAR_W  = 6;
	localparam int EXP_W   = 3;   // index of the leading decimal place, 0..4
	localparam int FRAC_W  = 32;  // fraction bits of the fixed-point quotient
	localparam int RECIP_W = FRAC_W + 1;
	localparam int PROD_W  = VALUE_W + RECIP_W;
	localparam int STEP_W  = FRAC_W + DIGIT_W;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

	localparam logic [EXP_W-1:0] EXP_ONES   = 3'd0;
	localparam logic [EXP_W-1:0] EXP_TENS   = 3'd1;
	localparam logic [EXP_W-1:0] EXP_HUNDS  = 3'd2;
	localparam logic [EXP_W-1:0] EXP_THOUS  = 3'd3;
	localparam logic [EXP_W-1:0] EXP_TTHOUS = 3'd4;

	// Rounded-up 2^32 / 10^exp; the integer part of value * recip is the
	// leading digit and the error stays below one unit of the last digit.
	function automatic logic [RECIP_W-1:0] recip(input logic [EXP_W-1:0] exp_sel);
		logic [RECIP_W-1:0] r;
		unique case (exp_sel)
			EXP_ONES:   r = 33'h1_0000_0000;
			EXP_TENS:   r = 33'h0_1999_999A;
			EXP_HUNDS:  r = 33'h0_028F_5C29;
			EXP_THOUS:  r = 33'h0_0041_8938;
			EXP_TTHOUS: r = 33'h0_0006_8DB9;
			default:    r = 33'h1_0000_0000;
		endcase
		return r;
	endfunction

	typedef struct packed {
		logic load;   // capture a new value and its digit count
		logic mul;    // form the leading digit into the output register
		logic step;   // advance to the next digit
		logic clear;  // drop the output word
	} b2da_cmd_t;

	typedef struct packed {
		logic out_free;   // output register empty or being taken
		logic out_taken;  // output word taken this cycle
		logic last;       // output register holds the final digit
	} b2da_sts_t;

endpackage

>>> hdl/b2da_ctrl.sv
// ---------------------------------------------------------------------------
// b2da_ctrl
// Sequencer: accept a value, start the conversion, walk out the digits.
// ---------------------------------------------------------------------------
module b2da_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  b2da_pkg::b2da_sts_t  sts,
	output b2da_pkg::b2da_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				// wait for the previous final word to leave
				if (sts.out_free) begin
					cmd.mul = 1'b1;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				in_ready = sts.last;
				if (sts.out_taken) begin
					if (!sts.last) begin
						cmd.step = 1'b1;
					end else begin
						cmd.clear = 1'b1;
						state_d   = ST_IDLE;
					end
				end
				if (sts.last && in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hdl/b2da_dp.sv
// ---------------------------------------------------------------------------
// b2da_dp
// Datapath: reciprocal multiply for the leading digit, then times ten per
// digit on the fraction, with the output word register.
// ---------------------------------------------------------------------------
module b2da_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [b2da_pkg::VALUE_W-1:0]        value,
	input  b2da_pkg::b2da_cmd_t                 cmd,
	output b2da_pkg::b2da_sts_t                 sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [b2da_pkg::CHAR_W-1:0]         ascii_char,
	output logic                                is_last
);

	logic [b2da_pkg::VALUE_W-1:0] v_q;
	logic [b2da_pkg::EXP_W-1:0]   exp_q;
	logic [b2da_pkg::FRAC_W-1:0]  frac_q;
	logic [b2da_pkg::CHAR_W-1:0]  char_q;
	logic                         last_q;
	logic                         out_valid_q;

	logic [b2da_pkg::EXP_W-1:0]   exp_in;
	logic [b2da_pkg::PROD_W-1:0]  prod;
	logic [b2da_pkg::STEP_W-1:0]  times10;
	logic [b2da_pkg::DIGIT_W-1:0] digit;
	logic [b2da_pkg::FRAC_W-1:0]  frac_nxt;

	// leading decimal place of the incoming value
	always_comb begin
		if (value >= 16'd10000) begin
			exp_in = b2da_pkg::EXP_TTHOUS;
		end else if (value >= 16'd1000) begin
			exp_in = b2da_pkg::EXP_THOUS;
		end else if (value >= 16'd100) begin
			exp_in = b2da_pkg::EXP_HUNDS;
		end else if (value >= 16'd10) begin
			exp_in = b2da_pkg::EXP_TENS;
		end else begin
			exp_in = b2da_pkg::EXP_ONES;
		end
	end

	assign prod    = b2da_pkg::PROD_W'(v_q) * b2da_pkg::PROD_W'(b2da_pkg::recip(exp_q));
	assign times10 = (b2da_pkg::STEP_W'(frac_q) << 3) + (b2da_pkg::STEP_W'(frac_q) << 1);

	always_comb begin
		if (cmd.mul) begin
			digit    = prod[b2da_pkg::STEP_W-1:b2da_pkg::FRAC_W];
			frac_nxt = prod[b2da_pkg::FRAC_W-1:0];
		end else begin
			digit    = times10[b2da_pkg::STEP_W-1:b2da_pkg::FRAC_W];
			frac_nxt = times10[b2da_pkg::FRAC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.mul || cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (cmd.clear) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q <= value;
		end
		if (cmd.load) begin
			exp_q <= exp_in;
		end else if (cmd.step) begin
			exp_q <= exp_q - 3'd1;
		end
		if (cmd.mul || cmd.step) begin
			frac_q <= frac_nxt;
			char_q <= b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(digit);
		end
		if (cmd.mul) begin
			last_q <= (exp_q == b2da_pkg::EXP_ONES);
		end else if (cmd.step) begin
			last_q <= (exp_q == b2da_pkg::EXP_TENS);
		end
	end

	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.out_taken = out_valid_q && out_ready;
	assign sts.last      = last_q;

	assign out_valid  = out_valid_q;
	assign ascii_char = char_q;
	assign is_last    = last_q;

endmodule

>>> hdl/binary_to_decimal_ascii.sv
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts an unsigned 16-bit value into its decimal digits as ASCII codes,
// most significant first, leading zeros suppressed, last digit flagged.
// ---------------------------------------------------------------------------
//
//  channel | signals                         | direction | word
//  --------+---------------------------------+-----------+----------------------
//  in      | in_valid, in_ready, value       | sink      | one 16-bit value
//  out     | out_valid, out_ready,           | source    | one digit character,
//          | ascii_char, is_last             |           | is_last on the final
//
//  A value of n digits (1..5) passes through a reciprocal multiply that forms
//  the leading digit, then one digit per cycle with an ever-ready sink from a
//  times-ten step on the fraction. The next value is taken while the final
//  digit of a run waits at the output. Reset clears the sequencer and the
//  output valid; data registers hold junk. A stalled sink holds the output
//  word; the sequencer waits, but may take the next value while the final
//  digit is held.
// ---------------------------------------------------------------------------
module binary_to_decimal_ascii (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [b2da_pkg::VALUE_W-1:0]  value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [b2da_pkg::CHAR_W-1:0]   ascii_char,
	output logic                          is_last
);

	b2da_pkg::b2da_cmd_t cmd;
	b2da_pkg::b2da_sts_t sts;

	// sequencer: issue load, multiply, step and clear
	b2da_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: hold the value, form digits, drive the output word
	b2da_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ascii_char (ascii_char),
		.is_last    (is_last)
	);

`ifndef ASSERT_OFF
	// one value in flight: after a take, the input closes for the multiply
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken twice in a row");

	// digits of one run leave back to back
	a_run_unbroken: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !is_last) |=> out_valid)
		else $error("gap inside a digit run");

	// no new value while a run is still mid-way
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_last) |-> !in_ready)
		else $error("input open during a digit run");

	// every word is a decimal digit character
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ascii_char[5:4] == 2'b11 && ascii_char[3:0] <= 4'd9))
		else $error("output word is not a decimal digit");

	// at most one of load, multiply and step per cycle
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.mul, cmd.step}))
		else $error("conflicting datapath commands");
`endif

endmodule
